@@ hdl/zlhm_pkg.sv @@
// ----------------------------------------------------------------------------
// zlhm_pkg: shared types and constants
// Field widths, command codes and memory entry layouts for the zone latency
// histogram monitor.
// ----------------------------------------------------------------------------
package zlhm_pkg;

    // sizing
    localparam int ZONES     = 32;
    localparam int BUCKETS   = 32;
    localparam int ZW        = $clog2(ZONES);
    localparam int AW        = $clog2(ZONES + 1);
    localparam int BW        = $clog2(BUCKETS);
    localparam int BAW       = ZW + BW;
    localparam int CLR_W     = $clog2(ZONES * BUCKETS);

    // field widths
    localparam int ZID_W     = 6;
    localparam int CNT_W     = 48;
    localparam int SUM_W     = 64;
    localparam int TICK_W    = 48;
    localparam int BYTE_W    = 32;
    localparam int P95_W     = 32;
    localparam int CUM_W     = CNT_W + BW + 1;
    localparam int THR_W     = CNT_W + 7;

    // stream payload widths
    localparam int S_DATA_W  = 88;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 304;
    localparam int M_USER_W  = 1;

    // commands
    typedef enum logic [1:0] {
        CMD_REC_TIME = 2'd0,
        CMD_REC_ACC  = 2'd1,
        CMD_RD_TIME  = 2'd2,
        CMD_RD_ACC   = 2'd3
    } t_cmd;

    // report kinds
    localparam logic KIND_TIME = 1'b0;
    localparam logic KIND_ACC  = 1'b1;

    // per-zone timing entry
    typedef struct packed {
        logic [CNT_W-1:0]  calls;
        logic [SUM_W-1:0]  sum;
        logic [TICK_W-1:0] peak;
    } t_zone_ent;

    // access counter entry
    typedef struct packed {
        logic [CNT_W-1:0]  calls;
        logic [SUM_W-1:0]  bytes;
        logic [CNT_W-1:0]  fails;
        logic [SUM_W-1:0]  sum;
        logic [TICK_W-1:0] peak;
    } t_acc_ent;

    // floor(log2(t)) clamped to the last bucket, t nonzero
    function automatic logic [BW-1:0] bucket_of(input logic [TICK_W-1:0] t);
        int b;
        b = 0;
        for (int k = 1; k < TICK_W; k++) begin
            if (t[k]) begin
                b = k;
            end
        end
        if (b > BUCKETS - 1) begin
            b = BUCKETS - 1;
        end
        return BW'(b);
    endfunction

endpackage

@@ hdl/zone_latency_histogram_monitor.sv @@
// ----------------------------------------------------------------------------
// zone_latency_histogram_monitor
// Per-zone latency and access profiler with log2 histograms and read-and-clear
// reports, built around one shared saturating adder under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream (tuser = command, tdata = zone, ticks,
//   bytes, ok flag). Record commands produce no output; read commands produce
//   one report transfer on the m_ stream (tuser = report kind) unless ignored.
//   A command is taken only while the sequencer is idle; s_tready is low while
//   a command is worked on and while a report waits on the m_ side.
//   Steps for one command, accept to ready again:
//     timing record: read, fetch, three adder steps, write back
//     access record: read, fetch, adder steps and write back for the global
//       entry, and again for the zone entry when the zone is in range
//     timing read: read, fetch, read/add/compare per bucket, then the report
//     access read: read, fetch, then the report
//   The histogram walk through the bucket memory sets the timing read latency;
//   the single adder sets the record latency; ignored commands stay idle.
//   After reset a clearing pass writes zeros to all memories, one bucket
//   address per cycle, 1024 (ZONES*BUCKETS) in all; no command is taken then.
//   A stalled receiver holds the report in the output register and holds off
//   new commands until it is taken.
// ----------------------------------------------------------------------------
module zone_latency_histogram_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // zone_id[5:0], elapsed_ticks[53:6], byte_count[85:54], access_ok[86], pad
    input  logic [zlhm_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [zlhm_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // call_count[47:0], tick_total[111:48], tick_peak[159:112],
    // tick_p95_bound[191:160], byte_total[255:192], failure_count[303:256]
    output logic [zlhm_pkg::M_DATA_W-1:0] m_tdata,
    // report_kind[0]
    output logic [zlhm_pkg::M_USER_W-1:0] m_tuser
);
    import zlhm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_FETCH, S_ALU, S_WB,
        S_WALK_RD, S_WALK_ADD, S_WALK_CMP, S_REPORT, S_OUT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [CLR_W-1:0]    r_clr;
    logic [ZW-1:0]       r_zone;
    logic                r_zvalid;
    logic [AW-1:0]       r_aidx;
    logic [BW-1:0]       r_bidx;
    logic [BW-1:0]       r_pb;
    logic                r_found;
    logic [1:0]          r_op;
    logic [TICK_W-1:0]   r_ticks;
    logic [BYTE_W-1:0]   r_bytes_in;
    logic                r_ok;
    logic [CNT_W-1:0]    r_calls;
    logic [SUM_W-1:0]    r_sum;
    logic [TICK_W-1:0]   r_peak;
    logic [SUM_W-1:0]    r_bytes;
    logic [CNT_W-1:0]    r_fails;
    logic [CNT_W-1:0]    r_bkt;
    logic [CUM_W-1:0]    r_cum;
    logic [THR_W-1:0]    r_thr;
    logic                r_m_tvalid;
    logic [M_DATA_W-1:0] r_m_tdata;
    logic [M_USER_W-1:0] r_m_tuser;

    // memories and their registered read data
    t_zone_ent           zmem [ZONES];
    t_acc_ent            amem [ZONES+1];
    logic [CNT_W-1:0]    bmem [ZONES*BUCKETS];
    t_zone_ent           r_zq;
    t_acc_ent            r_aq;
    logic [CNT_W-1:0]    r_bq;

    logic                z_we, a_we, b_we;
    logic [ZW-1:0]       z_wa;
    logic [AW-1:0]       a_wa;
    logic [BAW-1:0]      b_wa;
    t_zone_ent           z_wd;
    t_acc_ent            a_wd;
    logic [CNT_W-1:0]    b_wd;
    logic [BAW-1:0]      b_ra;

    // input fields
    logic [ZID_W-1:0]    in_zid;
    logic [TICK_W-1:0]   in_ticks;
    logic [BYTE_W-1:0]   in_bytes;
    logic                in_ok;
    t_cmd                in_cmd;
    logic                in_valid;

    // shared saturating adder
    logic [SUM_W-1:0]    u_a, u_b, u_res;
    logic                u_narrow;
    logic [SUM_W:0]      u_sum;

    logic                cmp_ge;
    logic [BW-1:0]       pb_sel;
    logic [P95_W-1:0]    p95;
    logic                last_op;

    assign in_zid   = s_tdata[5:0];
    assign in_ticks = s_tdata[53:6];
    assign in_bytes = s_tdata[85:54];
    assign in_ok    = s_tdata[86];
    assign in_cmd   = t_cmd'(s_tuser[1:0]);
    assign in_valid = 32'(in_zid) < ZONES;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

    assign b_ra     = {r_zone, r_bidx};
    assign last_op  = (r_cmd == CMD_REC_TIME) ? (r_op == 2'd2) : (r_op == 2'd3);

    // operand select for the shared adder
    always_comb begin
        u_a      = '0;
        u_b      = '0;
        u_narrow = 1'b1;
        if (r_state == S_WALK_ADD) begin
            u_a      = SUM_W'(r_cum);
            u_b      = SUM_W'(r_bq);
            u_narrow = 1'b0;
        end else if (r_cmd == CMD_REC_TIME) begin
            case (r_op)
                2'd0:    begin u_a = SUM_W'(r_calls); u_b = SUM_W'(1'b1); end
                2'd1:    begin u_a = r_sum; u_b = SUM_W'(r_ticks); u_narrow = 1'b0; end
                default: begin u_a = SUM_W'(r_bkt); u_b = SUM_W'(1'b1); end
            endcase
        end else begin
            case (r_op)
                2'd0:    begin u_a = SUM_W'(r_calls); u_b = SUM_W'(1'b1); end
                2'd1:    begin u_a = r_bytes; u_b = SUM_W'(r_bytes_in); u_narrow = 1'b0; end
                2'd2:    begin u_a = SUM_W'(r_fails); u_b = SUM_W'(!r_ok); end
                default: begin u_a = r_sum; u_b = SUM_W'(r_ticks); u_narrow = 1'b0; end
            endcase
        end
    end

    // saturating add, at the counter width or the sum width
    always_comb begin
        u_sum = {1'b0, u_a} + {1'b0, u_b};
        if (u_narrow) begin
            u_res = (|u_sum[SUM_W:CNT_W]) ? SUM_W'({CNT_W{1'b1}}) : u_sum[SUM_W-1:0];
        end else begin
            u_res = u_sum[SUM_W] ? '1 : u_sum[SUM_W-1:0];
        end
    end

    // percentile compare without division: cum >= ceil(95*calls/100)
    assign cmp_ge = ((CUM_W+7)'(r_cum) * (CUM_W+7)'(100)) >= (CUM_W+7)'(r_thr);

    // percentile bound: ones up to and including the chosen bucket
    assign pb_sel = r_found ? r_pb : BW'(BUCKETS - 1);
    always_comb begin
        for (int k = 0; k < P95_W; k++) begin
            p95[k] = (r_calls != '0) && (k <= 32'(pb_sel));
        end
    end

    // memory write ports
    always_comb begin
        z_we = 1'b0;
        z_wa = r_zone;
        z_wd = '{calls: r_calls, sum: r_sum,
                 peak: (r_ticks > r_peak) ? r_ticks : r_peak};
        a_we = 1'b0;
        a_wa = r_aidx;
        a_wd = '{calls: r_calls, bytes: r_bytes, fails: r_fails, sum: r_sum,
                 peak: (r_ticks > r_peak) ? r_ticks : r_peak};
        b_we = 1'b0;
        b_wa = b_ra;
        b_wd = r_bkt;
        unique case (r_state)
            S_CLEAR: begin
                z_we = 32'(r_clr) < ZONES;
                z_wa = r_clr[ZW-1:0];
                z_wd = '0;
                a_we = 32'(r_clr) < ZONES + 1;
                a_wa = r_clr[AW-1:0];
                a_wd = '0;
                b_we = 1'b1;
                b_wa = BAW'(r_clr);
                b_wd = '0;
            end
            S_WB: begin
                z_we = (r_cmd == CMD_REC_TIME);
                b_we = (r_cmd == CMD_REC_TIME);
                a_we = (r_cmd == CMD_REC_ACC);
            end
            S_WALK_ADD: begin
                b_we = 1'b1;
                b_wd = '0;
            end
            S_REPORT: begin
                z_we = (r_cmd == CMD_RD_TIME);
                z_wd = '0;
                a_we = (r_cmd == CMD_RD_ACC);
                a_wd = '0;
            end
            default: begin
            end
        endcase
    end

    // zone timing memory
    always_ff @(posedge i_clk) begin
        if (z_we) begin
            zmem[z_wa] <= z_wd;
        end
        r_zq <= zmem[r_zone];
    end

    // access counter memory
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            amem[a_wa] <= a_wd;
        end
        r_aq <= amem[r_aidx];
    end

    // histogram bucket memory
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            bmem[b_wa] <= b_wd;
        end
        r_bq <= bmem[b_ra];
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (r_clr == CLR_W'(ZONES * BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_cmd      <= in_cmd;
                        r_zone     <= in_zid[ZW-1:0];
                        r_zvalid   <= in_valid;
                        r_ticks    <= in_ticks;
                        r_bytes_in <= in_bytes;
                        r_ok       <= in_ok;
                        r_bidx     <= bucket_of(in_ticks);
                        r_aidx     <= (in_cmd == CMD_RD_ACC && in_valid)
                                      ? AW'(in_zid) : AW'(ZONES);
                        unique case (in_cmd)
                            CMD_REC_TIME: begin
                                if (in_valid && in_ticks != '0) begin
                                    r_state <= S_LOAD;
                                end
                            end
                            CMD_RD_TIME: begin
                                if (in_valid) begin
                                    r_state <= S_LOAD;
                                end
                            end
                            default: r_state <= S_LOAD;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_op <= 2'd0;
                    if (r_cmd == CMD_REC_TIME || r_cmd == CMD_RD_TIME) begin
                        r_calls <= r_zq.calls;
                        r_sum   <= r_zq.sum;
                        r_peak  <= r_zq.peak;
                        r_bytes <= '0;
                        r_fails <= '0;
                    end else begin
                        r_calls <= r_aq.calls;
                        r_sum   <= r_aq.sum;
                        r_peak  <= r_aq.peak;
                        r_bytes <= r_aq.bytes;
                        r_fails <= r_aq.fails;
                    end
                    r_bkt   <= r_bq;
                    r_thr   <= THR_W'(r_zq.calls) * THR_W'(95);
                    r_cum   <= '0;
                    r_found <= 1'b0;
                    unique case (r_cmd)
                        CMD_RD_TIME: begin
                            r_bidx  <= '0;
                            r_state <= S_WALK_RD;
                        end
                        CMD_RD_ACC: r_state <= S_REPORT;
                        default:    r_state <= S_ALU;
                    endcase
                end
                S_ALU: begin
                    if (r_cmd == CMD_REC_TIME) begin
                        case (r_op)
                            2'd0:    r_calls <= u_res[CNT_W-1:0];
                            2'd1:    r_sum   <= u_res;
                            default: r_bkt   <= u_res[CNT_W-1:0];
                        endcase
                    end else begin
                        case (r_op)
                            2'd0:    r_calls <= u_res[CNT_W-1:0];
                            2'd1:    r_bytes <= u_res;
                            2'd2:    r_fails <= u_res[CNT_W-1:0];
                            default: r_sum   <= u_res;
                        endcase
                    end
                    r_op <= r_op + 2'd1;
                    if (last_op) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    // global access entry first, then the zone entry
                    if (r_cmd == CMD_REC_ACC && r_aidx == AW'(ZONES) && r_zvalid) begin
                        r_aidx  <= AW'(r_zone);
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_WALK_RD: begin
                    r_state <= S_WALK_ADD;
                end
                S_WALK_ADD: begin
                    r_cum   <= u_res[CUM_W-1:0];
                    r_state <= S_WALK_CMP;
                end
                S_WALK_CMP: begin
                    if (!r_found && cmp_ge) begin
                        r_found <= 1'b1;
                        r_pb    <= r_bidx;
                    end
                    if (r_bidx == BW'(BUCKETS - 1)) begin
                        r_state <= S_REPORT;
                    end else begin
                        r_bidx  <= r_bidx + BW'(1);
                        r_state <= S_WALK_RD;
                    end
                end
                S_REPORT: begin
                    r_m_tvalid <= 1'b1;
                    r_m_tuser  <= (r_cmd == CMD_RD_ACC) ? KIND_ACC : KIND_TIME;
                    r_m_tdata  <= {r_fails, r_bytes,
                                   (r_cmd == CMD_RD_ACC) ? P95_W'(0) : p95,
                                   r_peak, r_sum, r_calls};
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        r_m_tvalid <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/zone_latency_histogram_monitor_tb.sv @@
// ----------------------------------------------------------------------------
// zone_latency_histogram_monitor_tb: self-checking testbench
// Streams timing records, access records and read commands into the monitor,
// keeps its own copy of every zone's counters and histogram, and checks each
// report field by field, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zone_latency_histogram_monitor_tb;
    import zlhm_pkg::*;

    localparam logic [CNT_W-1:0] CNT_TOP = '1;
    localparam logic [SUM_W-1:0] SUM_TOP = '1;
    localparam int IDLE_LIMIT = 6000;
    localparam int N_RANDOM = 830;
    localparam int CALM_AFTER = 700;

    typedef struct packed {
        t_cmd              cmd;
        logic [ZID_W-1:0]  zid;
        logic [TICK_W-1:0] ticks;
        logic [BYTE_W-1:0] nbytes;
        logic              ok;
    } t_item;

    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  calls;
        logic [SUM_W-1:0]  total;
        logic [TICK_W-1:0] peak;
        logic [P95_W-1:0]  p95;
        logic [SUM_W-1:0]  nbytes;
        logic [CNT_W-1:0]  fails;
    } t_report;

    logic i_clk;
    logic i_rst_n;
    logic s_tvalid;
    logic s_tready;
    // zone_id, elapsed_ticks, byte_count, access_ok, pad
    logic [S_DATA_W-1:0] s_tdata;
    // cmd
    logic [S_USER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    // call_count, tick_total, tick_peak, tick_p95_bound, byte_total, failure_count
    logic [M_DATA_W-1:0] m_tdata;
    // report_kind
    logic [M_USER_W-1:0] m_tuser;

    zone_latency_histogram_monitor uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // mirrored monitor state
    logic [CNT_W-1:0]  tm_calls [ZONES];
    logic [SUM_W-1:0]  tm_sum   [ZONES];
    logic [TICK_W-1:0] tm_peak  [ZONES];
    logic [CNT_W-1:0]  tm_hist  [ZONES][BUCKETS];
    logic [CNT_W-1:0]  ac_calls [ZONES+1];
    logic [SUM_W-1:0]  ac_bytes [ZONES+1];
    logic [CNT_W-1:0]  ac_fails [ZONES+1];
    logic [SUM_W-1:0]  ac_sum   [ZONES+1];
    logic [TICK_W-1:0] ac_peak  [ZONES+1];

    t_item   pending_cmds [$];
    t_report due_reports  [$];
    int      mismatches = 0;
    int      sent = 0;
    int      src_gap = 0;
    int      snk_gap = 0;
    int      idle_cycles = 0;
    bit      cmd_taken = 0;

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [CNT_W-1:0] cnt_inc(logic [CNT_W-1:0] c);
        return (c == CNT_TOP) ? c : c + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        return (a > SUM_TOP - b) ? SUM_TOP : a + b;
    endfunction

    function automatic int log2_bucket(logic [TICK_W-1:0] t);
        int b;
        b = 0;
        for (int k = 1; k < TICK_W; k++) begin
            if (t[k]) b = k;
        end
        return (b > BUCKETS - 1) ? BUCKETS - 1 : b;
    endfunction

    task automatic access_count(int i, t_item it);
        ac_calls[i] = cnt_inc(ac_calls[i]);
        ac_bytes[i] = sum_add(ac_bytes[i], SUM_W'(it.nbytes));
        if (!it.ok) ac_fails[i] = cnt_inc(ac_fails[i]);
        if (it.ticks != 0) begin
            ac_sum[i] = sum_add(ac_sum[i], SUM_W'(it.ticks));
            if (it.ticks > ac_peak[i]) ac_peak[i] = it.ticks;
        end
    endtask

    // update the mirrored counters and queue any report the command causes
    task automatic profile_command(t_item it);
        t_report r;
        logic [63:0] thr;
        logic [63:0] cum;
        bit found;
        bit in_range;
        int z;
        int b;
        int i;
        in_range = it.zid < ZONES;
        z = in_range ? int'(it.zid) : 0;
        r = '0;
        case (it.cmd)
            CMD_REC_TIME: begin
                if (in_range && it.ticks != 0) begin
                    b = log2_bucket(it.ticks);
                    tm_calls[z] = cnt_inc(tm_calls[z]);
                    tm_sum[z] = sum_add(tm_sum[z], SUM_W'(it.ticks));
                    if (it.ticks > tm_peak[z]) tm_peak[z] = it.ticks;
                    tm_hist[z][b] = cnt_inc(tm_hist[z][b]);
                end
            end
            CMD_REC_ACC: begin
                access_count(ZONES, it);
                if (in_range) access_count(z, it);
            end
            CMD_RD_TIME: begin
                if (in_range) begin
                    thr = (64'(tm_calls[z]) * 95 + 99) / 100;
                    cum = 0;
                    found = 0;
                    r.p95 = '1;
                    for (b = 0; b < BUCKETS; b++) begin
                        cum += 64'(tm_hist[z][b]);
                        if (!found && cum >= thr) begin
                            found = 1;
                            r.p95 = P95_W'((64'd1 << (b + 1)) - 1);
                        end
                        tm_hist[z][b] = '0;
                    end
                    if (tm_calls[z] == 0) r.p95 = '0;
                    r.kind = KIND_TIME;
                    r.calls = tm_calls[z];
                    r.total = tm_sum[z];
                    r.peak = tm_peak[z];
                    tm_calls[z] = '0;
                    tm_sum[z] = '0;
                    tm_peak[z] = '0;
                    due_reports.push_back(r);
                end
            end
            default: begin
                i = in_range ? z : ZONES;
                r.kind = KIND_ACC;
                r.calls = ac_calls[i];
                r.total = ac_sum[i];
                r.peak = ac_peak[i];
                r.nbytes = ac_bytes[i];
                r.fails = ac_fails[i];
                ac_calls[i] = '0;
                ac_bytes[i] = '0;
                ac_fails[i] = '0;
                ac_sum[i] = '0;
                ac_peak[i] = '0;
                due_reports.push_back(r);
            end
        endcase
    endtask

    task automatic queue_cmd(t_cmd c, int zid, logic [TICK_W-1:0] t,
                             logic [BYTE_W-1:0] nb, logic ok);
        t_item it;
        it.cmd = c;
        it.zid = ZID_W'(zid);
        it.ticks = t;
        it.nbytes = nb;
        it.ok = ok;
        pending_cmds.push_back(it);
    endtask

    // random durations spread over all magnitudes
    function automatic logic [TICK_W-1:0] rand_ticks();
        logic [TICK_W-1:0] t;
        t = TICK_W'({$urandom, $urandom});
        return t >> $urandom_range(0, TICK_W - 1);
    endfunction

    // source side: present the next command, with idle bursts
    always @(negedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || cmd_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                it = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, it.ok, it.nbytes, it.ticks, it.zid};
                s_tuser <= it.cmd;
                sent++;
                if (sent < CALM_AFTER && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 14);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side: ready with stall bursts
    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sent < CALM_AFTER && $urandom_range(0, 4) == 0)
                snk_gap = $urandom_range(1, 14);
        end
    end

    // monitor: check reports, mirror accepted commands, watch for a hang
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        t_item it;
        cmd_taken = i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.kind = m_tuser[0];
            got.calls = m_tdata[47:0];
            got.total = m_tdata[111:48];
            got.peak = m_tdata[159:112];
            got.p95 = m_tdata[191:160];
            got.nbytes = m_tdata[255:192];
            got.fails = m_tdata[303:256];
            if (due_reports.size() == 0) begin
                $error("unexpected report transfer, kind %0d", got.kind);
                mismatches++;
            end else begin
                want = due_reports.pop_front();
                if (got.kind != want.kind) begin
                    $error("report_kind: expected %0d, got %0d", want.kind, got.kind);
                    mismatches++;
                end
                if (got.calls != want.calls) begin
                    $error("call_count: expected %0d, got %0d", want.calls, got.calls);
                    mismatches++;
                end
                if (got.total != want.total) begin
                    $error("tick_total: expected %0d, got %0d", want.total, got.total);
                    mismatches++;
                end
                if (got.peak != want.peak) begin
                    $error("tick_peak: expected %0d, got %0d", want.peak, got.peak);
                    mismatches++;
                end
                if (got.p95 != want.p95) begin
                    $error("tick_p95_bound: expected %0d, got %0d", want.p95, got.p95);
                    mismatches++;
                end
                if (got.nbytes != want.nbytes) begin
                    $error("byte_total: expected %0d, got %0d", want.nbytes, got.nbytes);
                    mismatches++;
                end
                if (got.fails != want.fails) begin
                    $error("failure_count: expected %0d, got %0d", want.fails, got.fails);
                    mismatches++;
                end
            end
        end
        if (cmd_taken) begin
            it.zid = s_tdata[5:0];
            it.ticks = s_tdata[53:6];
            it.nbytes = s_tdata[85:54];
            it.ok = s_tdata[86];
            it.cmd = t_cmd'(s_tuser);
            profile_command(it);
        end
        // watchdog on transfer-free cycles
        if (cmd_taken || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int z;
        int r;
        t_cmd c;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        for (int k = 0; k < ZONES; k++) begin
            tm_calls[k] = '0;
            tm_sum[k] = '0;
            tm_peak[k] = '0;
            for (int b = 0; b < BUCKETS; b++) tm_hist[k][b] = '0;
        end
        for (int k = 0; k <= ZONES; k++) begin
            ac_calls[k] = '0;
            ac_bytes[k] = '0;
            ac_fails[k] = '0;
            ac_sum[k] = '0;
            ac_peak[k] = '0;
        end

        // directed: empty read, tick extremes, clamped bucket, no-zone cases
        queue_cmd(CMD_RD_TIME, 5, '0, '0, 1'b1);
        queue_cmd(CMD_REC_TIME, 0, 48'd1, '0, 1'b0);
        queue_cmd(CMD_REC_TIME, 0, 48'd0, '1, 1'b1);
        queue_cmd(CMD_REC_TIME, 0, 48'd3, '0, 1'b0);
        queue_cmd(CMD_REC_TIME, 0, 48'hFFFF_FFFF, '0, 1'b0);
        queue_cmd(CMD_REC_TIME, 0, 48'h1_0000_0000, '0, 1'b0);
        queue_cmd(CMD_REC_TIME, 0, '1, '0, 1'b0);
        queue_cmd(CMD_REC_TIME, 32, 48'd100, '0, 1'b0);
        queue_cmd(CMD_RD_TIME, 0, '0, '0, 1'b0);
        queue_cmd(CMD_RD_TIME, 63, '0, '0, 1'b0);
        // only the clamped bucket filled: bound saturates
        queue_cmd(CMD_REC_TIME, 31, '1, '0, 1'b1);
        queue_cmd(CMD_RD_TIME, 31, '0, '0, 1'b1);
        // access records: zero ticks, failures, no zone, byte extremes
        queue_cmd(CMD_REC_ACC, 31, '0, '1, 1'b0);
        queue_cmd(CMD_REC_ACC, 31, '1, '1, 1'b1);
        queue_cmd(CMD_REC_ACC, 32, 48'd7, 32'd0, 1'b0);
        queue_cmd(CMD_REC_ACC, 63, 48'd9, 32'd5, 1'b1);
        queue_cmd(CMD_RD_ACC, 31, '0, '0, 1'b0);
        queue_cmd(CMD_RD_ACC, 32, '0, '0, 1'b0);
        queue_cmd(CMD_RD_ACC, 63, '0, '0, 1'b1);
        queue_cmd(CMD_RD_ACC, 2, '0, '0, 1'b0);

        // random: few hot zones so histograms fill, occasional no-zone ids
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            c = (r < 45) ? CMD_REC_TIME : (r < 75) ? CMD_REC_ACC :
                (r < 88) ? CMD_RD_TIME : CMD_RD_ACC;
            r = $urandom_range(0, 9);
            z = (r < 7) ? $urandom_range(0, 3) : (r < 9) ? $urandom_range(0, ZONES - 1)
                                                        : $urandom_range(ZONES, 63);
            queue_cmd(c, z, ($urandom_range(0, 15) == 0) ? '0 : rand_ticks(),
                      $urandom, $urandom_range(0, 1));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || s_tvalid || due_reports.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
